>>> rtl/job_scheduler_fcfs_sjf_rr_assert.svh
// assertion macros for the job scheduler
`ifndef JOB_SCHEDULER_FCFS_SJF_RR_ASSERT_SVH
`define JOB_SCHEDULER_FCFS_SJF_RR_ASSERT_SVH

// clocked property, off while reset is low
`define JSCHED_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("job scheduler assertion failed");

// plain condition that must hold at every edge out of reset
`define JSCHED_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  `JSCHED_ASSERT(lbl, clk, rst_n, 1'b1 |-> (expr))

`endif

>>> rtl/jsched_pkg.sv
package jsched_pkg;

  localparam int unsigned SIZE_W  = 8;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned OUT_W   = 72;
  localparam int unsigned RUNID_W = 16;
  localparam int unsigned WCNT_W  = 5;
  localparam int unsigned TICK_W  = 32;

  localparam logic [MODE_W-1:0] MODE_FCFS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SJF  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RR   = 2'd2;

  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_SLICE = 1'b1;

  localparam logic [SIZE_W-1:0] SLICE_RESET = 8'd6;
  localparam logic [SIZE_W-1:0] SIZE_MAX    = 8'd255;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAKE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic wr;
    logic shift;
  } cell_ctrl_t;

endpackage

>>> rtl/job_scheduler_fcfs_sjf_rr.sv
// Tick-driven job scheduler (first come first served, shortest job first, round robin).
// Every input transfer is one time tick and yields exactly one output transfer. The wait
// queue is a row of QUEUE_DEPTH cells in arrival order. A tick goes from idle straight to
// execution when a job is already running or nothing waits, through a take state first when
// a job is picked in FCFS or round-robin mode, and through scan and then take in SJF mode,
// since the shortest-job search ripples through the row of cells one cell per cycle. A tick
// also stalls in execution while the output register holds an untaken result; the next tick
// is accepted while a result waits. Config writes go to cfg_idx_i 0 (mode) and 1 (quantum).
module job_scheduler_fcfs_sjf_rr import jsched_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_WIDTH    = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // job_size
  input  logic              s_axis_tuser,   // arrive
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // busy_res, run_id, run_left, job_done, preempted, arrival_dropped,
  // waiting_count, elapsed_ticks, zero fill
  output logic [OUT_W-1:0]  m_axis_tdata,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);
  localparam logic [CntW-1:0] DepthC = CntW'(QUEUE_DEPTH);
  localparam logic [CntW-1:0] ScanLast = CntW'(QUEUE_DEPTH - 1);

  state_e state_q, state_d;

  logic [CntW-1:0]     count_q;
  logic                cur_valid_q;
  logic [ID_WIDTH-1:0] cur_id_q;
  logic [SIZE_W-1:0]   cur_left_q;
  logic [SIZE_W-1:0]   used_q;
  logic [ID_WIDTH-1:0] next_id_q;
  logic [TICK_W-1:0]   tick_q;
  logic                dropped_q;
  logic [MODE_W-1:0]   mode_q;
  logic [SIZE_W-1:0]   slice_q;
  logic [CntW-1:0]     scan_cnt_q;
  logic                m_valid_q;
  logic [OUT_W-1:0]    m_data_q;

  logic s_fire, push_ok, out_free, exec_fire, take_sjf;
  logic [SIZE_W-1:0]   size_fix, left_nx, used_nx, quantum;
  logic                done, pre;
  cell_ctrl_t          ctrl;
  logic [ID_WIDTH-1:0] wr_id;
  logic [SIZE_W-1:0]   wr_size;
  logic [ID_WIDTH-1:0] take_id;
  logic [SIZE_W-1:0]   take_size;
  logic [IdxW-1:0]     take_pos;
  logic [31:0]         id_ext;
  logic [31:0]         cnt_ext;
  logic [OUT_W-1:0]    out_d;

  logic [ID_WIDTH-1:0] c_id      [QUEUE_DEPTH];
  logic [SIZE_W-1:0]   c_size    [QUEUE_DEPTH];
  logic [ID_WIDTH-1:0] n_id      [QUEUE_DEPTH];
  logic [SIZE_W-1:0]   n_size    [QUEUE_DEPTH];
  logic [ID_WIDTH-1:0] b_id      [QUEUE_DEPTH];
  logic [SIZE_W-1:0]   b_size    [QUEUE_DEPTH];
  logic [IdxW-1:0]     b_pos     [QUEUE_DEPTH];
  logic [ID_WIDTH-1:0] p_id      [QUEUE_DEPTH];
  logic [SIZE_W-1:0]   p_size    [QUEUE_DEPTH];
  logic [IdxW-1:0]     p_pos     [QUEUE_DEPTH];

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign n_id[g]   = '0;
      assign n_size[g] = '0;
    end else begin : g_mid
      assign n_id[g]   = c_id[g+1];
      assign n_size[g] = c_size[g+1];
    end
    if (g == 0) begin : g_first
      assign p_id[g]   = '0;
      assign p_size[g] = '0;
      assign p_pos[g]  = '0;
    end else begin : g_rest
      assign p_id[g]   = b_id[g-1];
      assign p_size[g] = b_size[g-1];
      assign p_pos[g]  = b_pos[g-1];
    end

    jsched_cell #(
      .IdW  (ID_WIDTH),
      .CntW (CntW),
      .IdxW (IdxW),
      .Idx  (g)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .count_i     (count_q),
      .pos_i       (take_pos),
      .wr_id_i     (wr_id),
      .wr_size_i   (wr_size),
      .nxt_id_i    (n_id[g]),
      .nxt_size_i  (n_size[g]),
      .prev_id_i   (p_id[g]),
      .prev_size_i (p_size[g]),
      .prev_pos_i  (p_pos[g]),
      .id_o        (c_id[g]),
      .size_o      (c_size[g]),
      .best_id_o   (b_id[g]),
      .best_size_o (b_size[g]),
      .best_pos_o  (b_pos[g])
    );
  end

  always_comb begin
    s_axis_tready = state_q == ST_IDLE;
    s_fire        = s_axis_tvalid && s_axis_tready;
    push_ok       = s_axis_tuser && (count_q < DepthC);
    size_fix      = (s_axis_tdata == '0) ? SIZE_W'(1) : s_axis_tdata;
    out_free      = !m_valid_q || m_axis_tready;
    exec_fire     = (state_q == ST_EXEC) && out_free;
    take_sjf      = mode_q == MODE_SJF;

    quantum = (slice_q == '0) ? SIZE_W'(1) : slice_q;
    left_nx = (cur_left_q != '0) ? cur_left_q - SIZE_W'(1) : cur_left_q;
    used_nx = (used_q == SIZE_MAX) ? used_q : used_q + SIZE_W'(1);
    done    = cur_valid_q && (left_nx == '0);
    pre     = cur_valid_q && !done && (mode_q == MODE_RR) && (used_nx >= quantum)
              && (count_q < DepthC);

    take_id   = take_sjf ? b_id[QUEUE_DEPTH-1]   : c_id[0];
    take_size = take_sjf ? b_size[QUEUE_DEPTH-1] : c_size[0];
    take_pos  = take_sjf ? b_pos[QUEUE_DEPTH-1]  : '0;

    ctrl.shift = state_q == ST_TAKE;
    ctrl.wr    = (s_fire && push_ok) || (exec_fire && pre);
    if (state_q == ST_EXEC) begin
      wr_id   = cur_id_q;
      wr_size = left_nx;
    end else begin
      wr_id   = next_id_q;
      wr_size = size_fix;
    end

    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          if (!cur_valid_q && (count_q != '0 || push_ok)) begin
            state_d = take_sjf ? ST_SCAN : ST_TAKE;
          end else begin
            state_d = ST_EXEC;
          end
        end
      end
      ST_SCAN: begin
        if (scan_cnt_q == ScanLast) begin
          state_d = ST_TAKE;
        end
      end
      ST_TAKE: state_d = ST_EXEC;
      ST_EXEC: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    id_ext  = cur_valid_q ? 32'(cur_id_q) : '0;
    cnt_ext = 32'(count_q + CntW'(pre));
    out_d = {7'd0, tick_q, cnt_ext[WCNT_W-1:0], dropped_q, pre, done,
             cur_valid_q ? left_nx : SIZE_W'(0), id_ext[RUNID_W-1:0], cur_valid_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      cur_valid_q <= 1'b0;
      cur_id_q    <= '0;
      cur_left_q  <= '0;
      used_q      <= '0;
      next_id_q   <= ID_WIDTH'(1);
      tick_q      <= '0;
      dropped_q   <= 1'b0;
      mode_q      <= MODE_FCFS;
      slice_q     <= SLICE_RESET;
      scan_cnt_q  <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_MODE:  mode_q  <= cfg_data_i[MODE_W-1:0];
          REG_SLICE: slice_q <= cfg_data_i[SIZE_W-1:0];
          default:   mode_q  <= mode_q;
        endcase
      end
      if (state_q == ST_SCAN) begin
        scan_cnt_q <= scan_cnt_q + CntW'(1);
      end else begin
        scan_cnt_q <= '0;
      end
      if (s_fire) begin
        tick_q    <= tick_q + TICK_W'(1);
        dropped_q <= s_axis_tuser && !push_ok;
        if (push_ok) begin
          count_q   <= count_q + CntW'(1);
          next_id_q <= next_id_q + ID_WIDTH'(1);
        end
      end
      if (state_q == ST_TAKE) begin
        count_q     <= count_q - CntW'(1);
        cur_valid_q <= 1'b1;
        cur_id_q    <= take_id;
        cur_left_q  <= take_size;
        used_q      <= '0;
      end
      if (exec_fire) begin
        m_valid_q <= 1'b1;
        if (cur_valid_q) begin
          cur_left_q <= left_nx;
          used_q     <= used_nx;
          if (done || pre) begin
            cur_valid_q <= 1'b0;
          end
          if (pre) begin
            count_q <= count_q + CntW'(1);
          end
        end
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      m_data_q <= out_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`include "job_scheduler_fcfs_sjf_rr_assert.svh"

  `JSCHED_ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= DepthC)
  `JSCHED_ASSERT(a_tick_step, clk_i, rst_ni, s_fire |=> tick_q == $past(tick_q) + TICK_W'(1))
  `JSCHED_ASSERT(a_take_runs, clk_i, rst_ni, state_q == ST_TAKE |=> cur_valid_q && state_q == ST_EXEC)
  `JSCHED_ASSERT(a_exec_out, clk_i, rst_ni, exec_fire |=> m_valid_q && state_q == ST_IDLE)

endmodule

>>> rtl/jsched_cell.sv
module jsched_cell import jsched_pkg::*; #(
  parameter int unsigned IdW  = 16,
  parameter int unsigned CntW = 5,
  parameter int unsigned IdxW = 4,
  parameter int unsigned Idx  = 0
) (
  input  logic              clk_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic [CntW-1:0]   count_i,
  input  logic [IdxW-1:0]   pos_i,
  input  logic [IdW-1:0]    wr_id_i,
  input  logic [SIZE_W-1:0] wr_size_i,
  input  logic [IdW-1:0]    nxt_id_i,
  input  logic [SIZE_W-1:0] nxt_size_i,
  input  logic [IdW-1:0]    prev_id_i,
  input  logic [SIZE_W-1:0] prev_size_i,
  input  logic [IdxW-1:0]   prev_pos_i,
  output logic [IdW-1:0]    id_o,
  output logic [SIZE_W-1:0] size_o,
  output logic [IdW-1:0]    best_id_o,
  output logic [SIZE_W-1:0] best_size_o,
  output logic [IdxW-1:0]   best_pos_o
);

  localparam logic [IdxW-1:0] OwnIdx = IdxW'(Idx);
  localparam logic [CntW-1:0] OwnCnt = CntW'(Idx);

  logic [IdW-1:0]    id_q;
  logic [SIZE_W-1:0] size_q;
  logic [IdW-1:0]    best_id_q, best_id_d;
  logic [SIZE_W-1:0] best_size_q, best_size_d;
  logic [IdxW-1:0]   best_pos_q, best_pos_d;
  logic              occupied;

  // running minimum, later entry wins a tie
  always_comb begin
    occupied = OwnCnt < count_i;
    if (Idx == 0 || (occupied && size_q <= prev_size_i)) begin
      best_id_d   = id_q;
      best_size_d = size_q;
      best_pos_d  = OwnIdx;
    end else begin
      best_id_d   = prev_id_i;
      best_size_d = prev_size_i;
      best_pos_d  = prev_pos_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift && OwnIdx >= pos_i) begin
      id_q   <= nxt_id_i;
      size_q <= nxt_size_i;
    end else if (ctrl_i.wr && OwnCnt == count_i) begin
      id_q   <= wr_id_i;
      size_q <= wr_size_i;
    end
    best_id_q   <= best_id_d;
    best_size_q <= best_size_d;
    best_pos_q  <= best_pos_d;
  end

  assign id_o        = id_q;
  assign size_o      = size_q;
  assign best_id_o   = best_id_q;
  assign best_size_o = best_size_q;
  assign best_pos_o  = best_pos_q;

endmodule

>>> test/job_scheduler_fcfs_sjf_rr_tb.sv
module job_scheduler_fcfs_sjf_rr_tb;
  import jsched_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WAIT_DEPTH = 16;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_TICKS = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic       arrive;
    logic [7:0] size;
  } tick_t;

  // same bit order as m_axis_tdata, elapsed ticks at the top
  typedef struct packed {
    logic [31:0] ticks;
    logic [4:0]  waiting;
    logic        dropped;
    logic        pre;
    logic        done;
    logic [7:0]  left;
    logic [15:0] job;
    logic        busy;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = REG_MODE;
  logic [CFG_W-1:0] cfg_data_i = '0;

  tick_t tick_queue[$];
  result_t want_results[$];
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  logic rx_hold = 1'b0;
  int err_cnt = 0;
  int cyc_cnt = 0;

  // scheduler state as seen by the checker
  logic [15:0] wq_id[WAIT_DEPTH];
  logic [7:0] wq_size[WAIT_DEPTH];
  int wq_cnt = 0;
  logic run_on = 1'b0;
  logic [15:0] run_job = '0;
  logic [7:0] run_rem = '0;
  logic [7:0] slice_cnt = '0;
  logic [15:0] id_next = 16'd1;
  logic [31:0] tick_cnt = '0;
  logic [MODE_W-1:0] cfg_mode = MODE_FCFS;
  logic [7:0] cfg_slice = SLICE_RESET;

  job_scheduler_fcfs_sjf_rr dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic bit wait_push(logic [15:0] id, logic [7:0] sz);
    if (wq_cnt >= WAIT_DEPTH) return 1'b0;
    wq_id[wq_cnt] = id;
    wq_size[wq_cnt] = sz;
    wq_cnt++;
    return 1'b1;
  endfunction

  function automatic result_t sched_tick(logic arrive, logic [7:0] size);
    result_t r;
    int pick;
    logic [7:0] quantum;
    logic [7:0] sz;
    r = '0;
    quantum = (cfg_slice == 0) ? 8'd1 : cfg_slice;
    tick_cnt++;
    if (arrive) begin
      sz = (size == 0) ? 8'd1 : size;
      if (wait_push(id_next, sz)) id_next++;
      else r.dropped = 1'b1;
    end
    if (!run_on && wq_cnt > 0) begin
      pick = 0;
      // shortest job, later arrival wins a tie
      if (cfg_mode == MODE_SJF) begin
        for (int i = 1; i < wq_cnt; i++) if (wq_size[i] <= wq_size[pick]) pick = i;
      end
      run_job = wq_id[pick];
      run_rem = wq_size[pick];
      for (int i = pick; i + 1 < wq_cnt; i++) begin
        wq_id[i] = wq_id[i+1];
        wq_size[i] = wq_size[i+1];
      end
      wq_cnt--;
      run_on = 1'b1;
      slice_cnt = '0;
    end
    if (run_on) begin
      r.busy = 1'b1;
      if (run_rem > 0) run_rem--;
      if (slice_cnt < 8'd255) slice_cnt++;
      r.job = run_job;
      r.left = run_rem;
      if (run_rem == 0) begin
        r.done = 1'b1;
        run_on = 1'b0;
      end else if (cfg_mode == MODE_RR && slice_cnt >= quantum) begin
        // a full queue keeps the job running
        if (wait_push(run_job, run_rem)) begin
          r.pre = 1'b1;
          run_on = 1'b0;
        end
      end
    end
    r.waiting = wq_cnt[4:0];
    r.ticks = tick_cnt;
    return r;
  endfunction

  task automatic flag_mismatch(string what, longint unsigned got_v, longint unsigned exp_v);
    err_cnt++;
    if (err_cnt <= 40) $display("mismatch %s: got %0h expected %0h", what, got_v, exp_v);
  endtask

  // input driver
  always @(posedge clk_i) begin : drv
    tick_t nxt;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        want_results.push_back(sched_tick(s_axis_tuser, s_axis_tdata));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tick_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          nxt = tick_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= nxt.arrive;
          s_axis_tdata <= nxt.size;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin : mon
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[64:0];
        if (want_results.size() == 0) begin
          flag_mismatch("unexpected transfer", 64'(got), '0);
        end else begin
          want = want_results.pop_front();
          if (got.busy !== want.busy)
            flag_mismatch("busy_res", 64'(got.busy), 64'(want.busy));
          if (got.job !== want.job) flag_mismatch("run_id", 64'(got.job), 64'(want.job));
          if (got.left !== want.left)
            flag_mismatch("run_left", 64'(got.left), 64'(want.left));
          if (got.done !== want.done)
            flag_mismatch("job_done", 64'(got.done), 64'(want.done));
          if (got.pre !== want.pre) flag_mismatch("preempted", 64'(got.pre), 64'(want.pre));
          if (got.dropped !== want.dropped)
            flag_mismatch("arrival_dropped", 64'(got.dropped), 64'(want.dropped));
          if (got.waiting !== want.waiting)
            flag_mismatch("waiting_count", 64'(got.waiting), 64'(want.waiting));
          if (got.ticks !== want.ticks)
            flag_mismatch("elapsed_ticks", 64'(got.ticks), 64'(want.ticks));
          if (m_axis_tdata[OUT_W-1:65] !== '0)
            flag_mismatch("zero fill", 64'(m_axis_tdata[OUT_W-1:65]), '0);
        end
      end
      m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic add_tick(logic arrive, logic [7:0] size);
    tick_queue.push_back({arrive, size});
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_MODE) cfg_mode = val[MODE_W-1:0];
    else cfg_slice = val;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (tick_queue.size() != 0 || s_axis_tvalid || want_results.size() != 0);
  endtask

  initial begin
    logic [MODE_W-1:0] mode_tab[RAND_PHASES];
    int slice_tab[RAND_PHASES];
    int arr_tab[RAND_PHASES];
    int pick;
    logic arrive;
    logic [7:0] size;

    mode_tab = '{MODE_FCFS, MODE_SJF, MODE_RR, MODE_RR, MODE_SJF, MODE_SPARE, MODE_RR,
      MODE_FCFS, MODE_RR, MODE_SJF, MODE_RR, MODE_SJF};
    slice_tab = '{6, 1, 1, 255, 0, 3, 2, 200, 0, 5, 1, 255};
    arr_tab = '{30, 90, 60, 25, 95, 40, 70, 15, 90, 50, 35, 80};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // idle tick, then fill the queue behind a long job until arrivals drop
    add_tick(1'b0, 8'hFF);
    add_tick(1'b1, 8'd255);
    add_tick(1'b1, 8'd0);
    add_tick(1'b1, 8'd1);
    for (int i = 0; i < 14; i++) add_tick(1'b1, 8'(3 + (i % 4)));
    add_tick(1'b1, 8'h80);
    add_tick(1'b1, 8'h7F);
    wait_idle();

    // round robin with quantum zero against a full queue
    write_reg(REG_MODE, CFG_W'(MODE_RR));
    write_reg(REG_SLICE, 8'd0);
    add_tick(1'b0, 8'h00);
    add_tick(1'b0, 8'hFF);
    add_tick(1'b1, 8'h55);
    add_tick(1'b0, 8'hAA);
    wait_idle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph < 4) begin
        tx_idle_pct = 7;
        rx_idle_pct = 73;
      end else if (ph < 8) begin
        tx_idle_pct = 73;
        rx_idle_pct = 7;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_reg(REG_MODE, CFG_W'(mode_tab[ph]));
      write_reg(REG_SLICE, CFG_W'(slice_tab[ph]));
      for (int i = 0; i < PHASE_TICKS; i++) begin
        arrive = $urandom_range(99) < arr_tab[ph];
        pick = $urandom_range(99);
        if (pick < 3) size = 8'd0;
        else if (pick < 5) size = 8'd255;
        else if (pick < 15) size = 8'($urandom_range(255));
        else size = 8'($urandom_range(6, 1));
        add_tick(arrive, size);
      end
      if (ph == 2) begin
        fork
          begin
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk_i);
            rx_hold <= 1'b0;
          end
        join_none
      end
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
